@@ hdl/jkse_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jkse_pkg
// Shared types, constants and helpers for the JSON key string extractor.
// ---------------------------------------------------------------------------
package jkse_pkg;

    // Key storage size
    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 8 * MAX_KEY_BYTES;
    localparam int KEY_LEN_W     = 4;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COPY,
        PH_ESC,
        PH_HEX,
        PH_DONE
    } t_phase;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_text;
        logic       key_found;
    } t_out;

    // All results caused by one input byte: up to three data bytes,
    // optionally followed by the end marker.
    typedef struct packed {
        logic [1:0]      n_bytes;
        logic [3:0][7:0] bytes;
        logic            is_last;
        logic            found;
    } t_burst;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

@@ hdl/jkse_step.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jkse_step
// Parser state, key registers and the per-byte update. Produces the burst
// of results for the byte being transferred.
// ---------------------------------------------------------------------------
module jkse_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [jkse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jkse_pkg::KEY_W-1:0]    i_cfg_data,
    input  wire logic                          i_fire,
    input  wire jkse_pkg::t_in                 i_in,
    output jkse_pkg::t_burst                   o_burst
);
    import jkse_pkg::*;

    logic [KEY_W-1:0]     r_key;
    logic [KEY_LEN_W-1:0] r_key_len;

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_mp,      n_mp;
    logic [1:0]  r_hcnt,    n_hcnt;
    logic [15:0] r_hval,    n_hval;
    logic        r_hstop,   n_hstop;
    logic [23:0] r_hraw,    n_hraw;
    logic        r_found,   n_found;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= KEY_LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:  r_key     <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and results for one byte
    always_comb begin
        logic [7:0]           b;
        logic [KEY_LEN_W-1:0] len;
        logic [3:0]           mp;
        logic [3:0]           mp_inc;
        logic [KEY_IDX_W-1:0] kidx;
        logic [7:0]           pc;
        t_hex                 hd;
        logic [15:0]          hv;

        b      = i_in.text_byte;
        len    = (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                 KEY_LEN_W'(MAX_KEY_BYTES) : r_key_len;
        mp     = (r_mp > 4'(len + 4'd3)) ? 4'd0 : r_mp;
        mp_inc = mp + 4'd1;
        kidx   = KEY_IDX_W'(mp - 4'd1);
        hd     = hex_digit(b);
        hv     = r_hval;

        n_phase = r_phase;
        n_mp    = r_mp;
        n_hcnt  = r_hcnt;
        n_hval  = r_hval;
        n_hstop = r_hstop;
        n_hraw  = r_hraw;
        n_found = r_found;

        o_burst = '0;

        // pattern character at the current match position
        if (mp == 4'd0 || mp == 4'(len + 4'd1) || mp == 4'(len + 4'd3)) begin
            pc = CH_QUOTE;
        end else if (mp == 4'(len + 4'd2)) begin
            pc = CH_COLON;
        end else begin
            pc = r_key[{kidx, 3'b000} +: 8];
        end

        unique case (r_phase)
            PH_SEARCH: begin
                if (b == pc) begin
                    n_mp = mp_inc;
                    if (mp_inc == 4'(len + 4'd4)) begin
                        n_phase = PH_COPY;
                        n_found = 1'b1;
                        n_mp    = 4'd0;
                    end
                end else begin
                    n_mp = (b == CH_QUOTE) ? 4'd1 : 4'd0;
                end
            end
            PH_COPY: begin
                if (b == CH_QUOTE) begin
                    n_phase = PH_DONE;
                end else if (b == CH_BSL && !i_in.last_byte) begin
                    n_phase = PH_ESC;
                end else begin
                    o_burst.n_bytes  = 2'd1;
                    o_burst.bytes[0] = b;
                end
            end
            PH_ESC: begin
                n_phase = PH_COPY;
                case (b)
                    CH_N: begin
                        o_burst.n_bytes  = 2'd1;
                        o_burst.bytes[0] = CH_LF;
                    end
                    CH_T: begin
                        o_burst.n_bytes  = 2'd1;
                        o_burst.bytes[0] = CH_TAB;
                    end
                    CH_R: ;
                    CH_U: begin
                        n_phase = PH_HEX;
                        n_hcnt  = 2'd0;
                        n_hval  = 16'd0;
                        n_hstop = 1'b0;
                        n_hraw  = 24'd0;
                    end
                    default: begin
                        o_burst.n_bytes  = 2'd1;
                        o_burst.bytes[0] = b;
                    end
                endcase
            end
            PH_HEX: begin
                if (!r_hstop && hd.valid) begin
                    hv = {r_hval[11:0], hd.value};
                end else begin
                    n_hstop = 1'b1;
                end
                n_hval = hv;
                if (r_hcnt == 2'd3) begin
                    // fourth digit: emit the code point as UTF-8
                    n_phase = PH_COPY;
                    if (hv < 16'h0080) begin
                        o_burst.n_bytes  = 2'd1;
                        o_burst.bytes[0] = hv[7:0];
                    end else if (hv < 16'h0800) begin
                        o_burst.n_bytes  = 2'd2;
                        o_burst.bytes[0] = 8'hC0 | {3'b000, hv[10:6]};
                        o_burst.bytes[1] = 8'h80 | {2'b00, hv[5:0]};
                    end else begin
                        o_burst.n_bytes  = 2'd3;
                        o_burst.bytes[0] = 8'hE0 | {4'b0000, hv[15:12]};
                        o_burst.bytes[1] = 8'h80 | {2'b00, hv[11:6]};
                        o_burst.bytes[2] = 8'h80 | {2'b00, hv[5:0]};
                    end
                end else if (i_in.last_byte) begin
                    // text ends inside the escape: give back the raw bytes
                    o_burst.n_bytes = r_hcnt + 2'd1;
                    case (r_hcnt)
                        2'd0: o_burst.bytes[0] = b;
                        2'd1: begin
                            o_burst.bytes[0] = r_hraw[7:0];
                            o_burst.bytes[1] = b;
                        end
                        default: begin
                            o_burst.bytes[0] = r_hraw[7:0];
                            o_burst.bytes[1] = r_hraw[15:8];
                            o_burst.bytes[2] = b;
                        end
                    endcase
                end else begin
                    n_hraw[{r_hcnt, 3'b000} +: 8] = b;
                    n_hcnt = r_hcnt + 2'd1;
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        // end of text: report and start over
        if (i_in.last_byte) begin
            o_burst.is_last = 1'b1;
            o_burst.found   = n_found;
            n_phase = PH_SEARCH;
            n_mp    = 4'd0;
            n_hcnt  = 2'd0;
            n_hval  = 16'd0;
            n_hstop = 1'b0;
            n_hraw  = 24'd0;
            n_found = 1'b0;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_mp    <= 4'd0;
            r_hcnt  <= 2'd0;
            r_hval  <= 16'd0;
            r_hstop <= 1'b0;
            r_hraw  <= 24'd0;
            r_found <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_mp    <= n_mp;
            r_hcnt  <= n_hcnt;
            r_hval  <= n_hval;
            r_hstop <= n_hstop;
            r_hraw  <= n_hraw;
            r_found <= n_found;
        end
    end

endmodule
`default_nettype wire

@@ hdl/jkse_outq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// jkse_outq
// Result register: holds the burst of one byte and hands its results out
// one transfer at a time.
// ---------------------------------------------------------------------------
module jkse_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire jkse_pkg::t_burst i_burst,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output jkse_pkg::t_out        o_data
);
    import jkse_pkg::*;

    t_burst     r_burst;
    logic       r_busy;
    logic [1:0] r_idx;
    logic [2:0] total;
    logic [2:0] in_total;
    logic       take;
    logic       done;

    assign total    = {1'b0, r_burst.n_bytes} + {2'b00, r_burst.is_last};
    assign in_total = {1'b0, i_burst.n_bytes} + {2'b00, i_burst.is_last};
    assign take     = r_busy && i_ready;
    assign done     = take && ({1'b0, r_idx} == total - 3'd1);

    assign o_valid    = r_busy;
    assign o_can_load = !r_busy || done;

    // Current result
    always_comb begin
        o_data = '0;
        if ({1'b0, r_idx} < {1'b0, r_burst.n_bytes}) begin
            o_data.out_byte = r_burst.bytes[r_idx];
            o_data.has_byte = 1'b1;
        end else begin
            o_data.end_of_text = 1'b1;
            o_data.key_found   = r_burst.found;
        end
        o_data.last_of_run = ({1'b0, r_idx} == total - 3'd1);
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_busy <= (in_total != 3'd0);
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/json_key_string_extractor_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// json_key_string_extractor_core
// Finds "key":" in a JSON byte stream and streams out the unescaped value.
// ---------------------------------------------------------------------------
// One text byte is taken per cycle while each byte yields at most one result
// and the output is ready. A byte yielding more than one result (a \u escape
// giving two or three UTF-8 bytes, the end marker after a data byte) stalls
// the input while the result register hands them out one per transfer; the
// next byte enters in the cycle the last is taken. The user must write the
// key via the config port while the block is idle; it does not enforce this.
module json_key_string_extractor_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [jkse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jkse_pkg::KEY_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire jkse_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output jkse_pkg::t_out                      o_out_data
);
    import jkse_pkg::*;

    t_burst burst;
    logic   fire;

    assign fire = i_in_valid && o_in_ready;

    // Parser and key registers
    jkse_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_in        (i_in_data),
        .o_burst     (burst)
    );

    // Result register and serializer
    jkse_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_burst    (burst),
        .o_can_load (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule
`default_nettype wire
